// File: hdl/nested_repeat_group_stack_macros.svh
// Assertion helpers used by the block that checks its own behavior.
`ifndef NESTED_REPEAT_GROUP_STACK_MACROS_SVH
`define NESTED_REPEAT_GROUP_STACK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRGS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NRGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hdl/nrgs_pkg.sv
`default_nettype none

package nrgs_pkg;

   localparam int MaxDepth = 16;
   // bits to hold a level count 0..MaxDepth, and to index a level
   localparam int CntW = $clog2(MaxDepth + 1);
   localparam int LvlW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

   localparam int CmdW   = 2;
   localparam int PosW   = 15;
   localparam int RepW   = 16;
   localparam int MacW   = 8;
   localparam int DepthW = 5;

   localparam logic [CmdW-1:0] CmdReset = 2'd0;
   localparam logic [CmdW-1:0] CmdBegin = 2'd1;
   localparam logic [CmdW-1:0] CmdEnd   = 2'd2;
   localparam logic [CmdW-1:0] CmdCheck = 2'd3;

   typedef struct packed {
      logic [CmdW-1:0] command;
      logic [PosW-1:0] position;
      logic [RepW-1:0] repeat_count;
      logic            macro_playing;
      logic [MacW-1:0] macro_id;
   } req_type;

   typedef struct packed {
      logic              jump;
      logic [PosW-1:0]   jump_position;
      logic              jump_via_macro;
      logic [MacW-1:0]   jump_macro_id;
      logic              clear_repeat;
      logic              end_matched;
      logic [DepthW-1:0] depth;
   } rsp_type;

   typedef struct packed {
      logic [RepW-1:0] reps;
      logic [PosW-1:0] start_pos;
      logic [PosW-1:0] end_pos;
      logic            end_set;
      logic            via_macro;
      logic [MacW-1:0] macro;
   } lvl_type;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'b01,
      ST_FULL  = 2'b10
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
   } ctl_cmd_type;

endpackage

`default_nettype wire

// File: hdl/nrgs_ctrl.sv
`default_nettype none

module nrgs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output nrgs_pkg::ctl_cmd_type     ctl_cmd
);

   nrgs_pkg::state_type state_ff;
   nrgs_pkg::state_type state_in;

   // take a new transaction whenever the output register is free or draining
   assign req_ready    = !reset && ((state_ff == nrgs_pkg::ST_EMPTY) || rsp_ready);
   assign rsp_valid    = (state_ff == nrgs_pkg::ST_FULL);
   assign ctl_cmd.load = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nrgs_pkg::ST_EMPTY: begin
            if (req_valid) state_in = nrgs_pkg::ST_FULL;
         end
         nrgs_pkg::ST_FULL: begin
            if (rsp_ready && !req_valid) state_in = nrgs_pkg::ST_EMPTY;
         end
         default: begin
            state_in = nrgs_pkg::ST_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrgs_pkg::ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/nrgs_dpath.sv
`default_nettype none

module nrgs_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nrgs_pkg::ctl_cmd_type  ctl_cmd,
   input  wire nrgs_pkg::req_type      req_data,
   output nrgs_pkg::rsp_type           rsp_data
);

   logic [nrgs_pkg::CntW-1:0] open_ff;
   logic [nrgs_pkg::CntW-1:0] open_in;
   logic [nrgs_pkg::CntW-1:0] open_m1;
   nrgs_pkg::lvl_type         lvl_ff [nrgs_pkg::MaxDepth];
   nrgs_pkg::lvl_type         lvl_in;
   nrgs_pkg::lvl_type         top;
   nrgs_pkg::rsp_type         rsp_ff;
   nrgs_pkg::rsp_type         rsp_in;
   logic [nrgs_pkg::LvlW-1:0] top_idx;
   logic [nrgs_pkg::LvlW-1:0] wr_idx;
   logic                      wr_en;
   logic                      has_top;
   logic                      full;
   logic                      end_hit;
   logic                      do_end;

   assign open_m1 = open_ff - nrgs_pkg::CntW'(1);
   assign top_idx = open_m1[nrgs_pkg::LvlW-1:0];
   assign has_top = (open_ff != '0);
   assign full    = (open_ff == nrgs_pkg::CntW'(nrgs_pkg::MaxDepth));
   assign top     = lvl_ff[top_idx];
   // an end position that was never recorded never matches
   assign end_hit = has_top && top.end_set && (top.end_pos == req_data.position);
   assign do_end  = ((req_data.command == nrgs_pkg::CmdEnd) && has_top) ||
                    ((req_data.command == nrgs_pkg::CmdCheck) && end_hit);

   always_comb begin
      open_in = open_ff;
      wr_en   = 1'b0;
      wr_idx  = top_idx;
      lvl_in  = top;
      rsp_in  = '0;
      case (req_data.command)
         nrgs_pkg::CmdReset: begin
            open_in = '0;
         end
         nrgs_pkg::CmdBegin: begin
            // drop the push when every level is in use
            if (!full) begin
               wr_en            = 1'b1;
               wr_idx           = open_ff[nrgs_pkg::LvlW-1:0];
               lvl_in.reps      = req_data.repeat_count;
               lvl_in.start_pos = req_data.position;
               lvl_in.end_pos   = '0;
               lvl_in.end_set   = 1'b0;
               lvl_in.via_macro = req_data.macro_playing;
               lvl_in.macro     = req_data.macro_playing ? req_data.macro_id : '0;
               open_in          = open_ff + nrgs_pkg::CntW'(1);
               rsp_in.clear_repeat = 1'b1;
            end
         end
         nrgs_pkg::CmdEnd, nrgs_pkg::CmdCheck: begin
            rsp_in.end_matched = (req_data.command == nrgs_pkg::CmdCheck) && end_hit;
            if (do_end) begin
               if (top.reps == '0) begin
                  open_in = open_m1;
               end else begin
                  wr_en = 1'b1;
                  if (!top.end_set) begin
                     lvl_in.end_pos = req_data.position;
                     lvl_in.end_set = 1'b1;
                  end
                  lvl_in.reps           = top.reps - nrgs_pkg::RepW'(1);
                  rsp_in.jump           = 1'b1;
                  rsp_in.jump_position  = top.start_pos;
                  rsp_in.jump_via_macro = top.via_macro;
                  rsp_in.jump_macro_id  = top.macro;
               end
            end
         end
         default: begin
            open_in = open_ff;
         end
      endcase
      rsp_in.depth = nrgs_pkg::DepthW'(open_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else if (ctl_cmd.load) begin
         open_ff <= open_in;
      end
   end

   // level contents need no reset: a level is fully written when pushed
   always_ff @(posedge clock) begin
      if (ctl_cmd.load && wr_en) begin
         lvl_ff[wr_idx] <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/nested_repeat_group_stack.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (nrgs_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (nrgs_pkg::rsp_type)
//
// One request per cycle unless rsp stalls; its result is registered for the next cycle.
// The top-of-stack read, compare and update of the level file happen in the same cycle.
// Reset (synchronous, active high) empties the stack and drops rsp_valid; rsp_data is kept.
// A request is taken while a result waits, as long as that result drains the same cycle.
`default_nettype none
`include "nested_repeat_group_stack_macros.svh"

module nested_repeat_group_stack (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire nrgs_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output nrgs_pkg::rsp_type       rsp_data
);

   nrgs_pkg::ctl_cmd_type ctl_cmd;
   logic                  depth_in_range;
   logic                  rsp_begin;
   logic                  begin_quiet;
   logic                  req_take;
   logic                  rsp_free;

   nrgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl_cmd   (ctl_cmd)
   );

   nrgs_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl_cmd  (ctl_cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign depth_in_range = (rsp_data.depth <= nrgs_pkg::DepthW'(nrgs_pkg::MaxDepth));
   assign rsp_begin      = rsp_valid && rsp_data.clear_repeat;
   assign begin_quiet    = !rsp_data.jump && !rsp_data.end_matched;
   assign req_take       = req_valid && req_ready;
   assign rsp_free       = !rsp_valid || rsp_ready;

   `NRGS_ASSERT_SAME(a_depth_bound, clock, reset, rsp_valid, depth_in_range)
   `NRGS_ASSERT_SAME(a_begin_no_jump, clock, reset, rsp_begin, begin_quiet)
   `NRGS_ASSERT_SAME(a_no_overwrite, clock, reset, req_take, rsp_free)
   `NRGS_ASSERT_NEXT(a_result_follows, clock, reset, req_take, rsp_valid)

endmodule

`default_nettype wire
